[src/efp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the escape-time fractal pixel block.
// Used by the controller, datapath, top level and checker.
package efp_pkg;

   localparam int MAX_DIM    = 4096;
   localparam int FRAC_BITS  = 28;
   localparam int ITER_WIDTH = 16;

   localparam int DIM_W    = $clog2(MAX_DIM);      // column / row width
   localparam int HEIGHT_W = DIM_W + 1;            // image height width
   localparam int WORD_W   = 32;                   // Q4.28 coordinate
   localparam int STEP_W   = 31;                   // unsigned pixel step
   localparam int PROD_W   = 2 * WORD_W;           // full-precision square
   localparam int POS_W    = DIM_W + STEP_W;       // position times step
   localparam int SUM_W    = POS_W + 2;            // room for sums before saturation
   localparam int COUNT_W  = 8;                    // reported count width
   localparam int CSR_IDX_W = 3;

   localparam int REQ_DATA_W = ((2 * DIM_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * DIM_W + COUNT_W + 7) / 8) * 8;

   // |z|^2 bound of 4.0 in the product format
   localparam int ESC_EXP = 2 * FRAC_BITS + 2;
   localparam logic [PROD_W-1:0] ESCAPE_BOUND =
      (ESC_EXP >= PROD_W) ? {PROD_W{1'b1}} : (PROD_W'(1) << ESC_EXP);

   localparam logic [STEP_W-1:0]     STEP_RESET   = STEP_W'(268435);
   localparam logic [ITER_WIDTH-1:0] LIMIT_RESET  = ITER_WIDTH'(255);
   localparam logic [HEIGHT_W-1:0]   HEIGHT_RESET = HEIGHT_W'(MAX_DIM);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE     = 3'd0,
      CSR_ORIGIN_RE = 3'd1,
      CSR_ORIGIN_IM = 3'd2,
      CSR_STEP     = 3'd3,
      CSR_LIMIT    = 3'd4,
      CSR_CONST_RE = 3'd5,
      CSR_CONST_IM = 3'd6,
      CSR_HEIGHT   = 3'd7
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic load_pos;   // capture the request
      logic scale;      // form position times step
      logic init;       // seed z and c
      logic mul;        // square z
      logic step;       // update z, advance count
      logic emit;       // load the result register
   } efp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done;       // escaped or limit reached
   } efp_status_type;

   // clamp to the signed word range
   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
      logic all_one;
      logic all_zero;
      all_one  = &v[SUM_W-1:WORD_W-1];
      all_zero = ~|v[SUM_W-1:WORD_W-1];
      if (all_one || all_zero)
         return v[WORD_W-1:0];
      else if (v[SUM_W-1])
         return {1'b1, {(WORD_W-1){1'b0}}};
      else
         return {1'b0, {(WORD_W-1){1'b1}}};
   endfunction

endpackage

[src/efp_ctrl.sv]
`timescale 1ns / 1ps
// Controller for the escape-time fractal pixel block: sequences setup, the
// iteration loop and result delivery. Depends on efp_pkg.
module efp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  efp_pkg::efp_status_type status,
   output efp_pkg::efp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_INIT,
      ST_MUL,
      ST_CHECK,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.load_pos = (state_ff == ST_IDLE) && req_tvalid;
      cmd.scale    = (state_ff == ST_SCALE);
      cmd.init     = (state_ff == ST_INIT);
      cmd.mul      = (state_ff == ST_MUL);
      cmd.step     = (state_ff == ST_CHECK) && !status.done;
      cmd.emit     = (state_ff == ST_EMIT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid)
                  state_ff <= ST_SCALE;
            end
            ST_SCALE: state_ff <= ST_INIT;
            ST_INIT:  state_ff <= ST_MUL;
            ST_MUL:   state_ff <= ST_CHECK;
            ST_CHECK: begin
               state_ff <= status.done ? ST_EMIT : ST_MUL;
            end
            ST_EMIT: begin
               // hold until the result register is free
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[src/efp_datapath.sv]
`timescale 1ns / 1ps
// Datapath for the escape-time fractal pixel block: configuration registers,
// point scaling, the z*z+c iteration and the result register. Depends on efp_pkg.
module efp_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [efp_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [efp_pkg::WORD_W-1:0]             csr_wdata,
   input  logic [efp_pkg::REQ_DATA_W-1:0]         req_tdata,
   output logic [efp_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input  efp_pkg::efp_cmd_type                   cmd,
   output efp_pkg::efp_status_type                status
);

   localparam int DW = efp_pkg::DIM_W;
   localparam int WW = efp_pkg::WORD_W;
   localparam int PW = efp_pkg::PROD_W;
   localparam int SW = efp_pkg::SUM_W;
   localparam int QW = efp_pkg::POS_W;
   localparam int IW = efp_pkg::ITER_WIDTH;
   localparam int HW = efp_pkg::HEIGHT_W;
   localparam int CW = efp_pkg::COUNT_W;

   // configuration
   logic                                mode_ff;
   logic signed [WW-1:0]                origin_re_ff;
   logic signed [WW-1:0]                origin_im_ff;
   logic [efp_pkg::STEP_W-1:0]          step_ff;
   logic [IW-1:0]                       limit_ff;
   logic signed [WW-1:0]                const_re_ff;
   logic signed [WW-1:0]                const_im_ff;
   logic [HW-1:0]                       height_ff;

   // work registers
   logic [DW-1:0]        col_ff;
   logic [DW-1:0]        row_ff;
   logic [QW-1:0]        pos_re_ff;
   logic [QW-1:0]        pos_im_ff;
   logic signed [WW-1:0] zr_ff;
   logic signed [WW-1:0] zi_ff;
   logic signed [WW-1:0] cr_ff;
   logic signed [WW-1:0] ci_ff;
   logic signed [PW-1:0] p_rr_ff;
   logic signed [PW-1:0] p_ii_ff;
   logic signed [PW-1:0] p_ri_ff;
   logic [IW-1:0]        count_ff;
   logic [efp_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic signed [SW-1:0] pt_re_sum;
   logic signed [SW-1:0] pt_im_sum;
   logic signed [WW-1:0] pt_re;
   logic signed [WW-1:0] pt_im;
   logic [PW-1:0]        mag_sq;
   logic                 in_radius;
   logic signed [PW-1:0] rr_diff;
   logic signed [PW-1:0] rr_shift;
   logic signed [PW-1:0] ri_shift;
   logic signed [SW-1:0] nr_sum;
   logic signed [SW-1:0] ni_sum;
   logic [HW-1:0]        flip_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         origin_re_ff <= '0;
         origin_im_ff <= '0;
         step_ff      <= efp_pkg::STEP_RESET;
         limit_ff     <= efp_pkg::LIMIT_RESET;
         const_re_ff  <= '0;
         const_im_ff  <= '0;
         height_ff    <= efp_pkg::HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (efp_pkg::csr_index_type'(csr_index))
            efp_pkg::CSR_MODE:      mode_ff      <= csr_wdata[0];
            efp_pkg::CSR_ORIGIN_RE: origin_re_ff <= csr_wdata;
            efp_pkg::CSR_ORIGIN_IM: origin_im_ff <= csr_wdata;
            efp_pkg::CSR_STEP:      step_ff      <= csr_wdata[efp_pkg::STEP_W-1:0];
            efp_pkg::CSR_LIMIT:     limit_ff     <= csr_wdata[IW-1:0];
            efp_pkg::CSR_CONST_RE:  const_re_ff  <= csr_wdata;
            efp_pkg::CSR_CONST_IM:  const_im_ff  <= csr_wdata;
            efp_pkg::CSR_HEIGHT:    height_ff    <= csr_wdata[HW-1:0];
            default: ;
         endcase
      end
   end

   // pixel point: origin plus position times step, clamped
   assign pt_re_sum = SW'(origin_re_ff) + signed'(SW'(pos_re_ff));
   assign pt_im_sum = SW'(origin_im_ff) + signed'(SW'(pos_im_ff));
   assign pt_re     = efp_pkg::sat_word(pt_re_sum);
   assign pt_im     = efp_pkg::sat_word(pt_im_sum);

   // escape test on the squares of the current z
   assign mag_sq = unsigned'(p_rr_ff) + unsigned'(p_ii_ff);
   assign in_radius = (mag_sq < efp_pkg::ESCAPE_BOUND);
   assign status.done = (count_ff >= limit_ff) || !in_radius;

   // next z; arithmetic shift rounds toward minus infinity
   assign rr_diff  = p_rr_ff - p_ii_ff;
   assign rr_shift = rr_diff >>> efp_pkg::FRAC_BITS;
   assign ri_shift = p_ri_ff >>> (efp_pkg::FRAC_BITS - 1);
   assign nr_sum   = SW'(rr_shift) + SW'(cr_ff);
   assign ni_sum   = SW'(ri_shift) + SW'(ci_ff);

   assign flip_row = height_ff - HW'(1) - HW'(row_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_pos) begin
         col_ff <= req_tdata[DW-1:0];
         row_ff <= req_tdata[2*DW-1:DW];
      end
      if (cmd.scale) begin
         pos_re_ff <= QW'(col_ff) * QW'(step_ff);
         pos_im_ff <= QW'(row_ff) * QW'(step_ff);
      end
      if (cmd.init) begin
         count_ff <= '0;
         if (mode_ff) begin
            zr_ff <= pt_re;
            zi_ff <= pt_im;
            cr_ff <= const_re_ff;
            ci_ff <= const_im_ff;
         end else begin
            zr_ff <= '0;
            zi_ff <= '0;
            cr_ff <= pt_re;
            ci_ff <= pt_im;
         end
      end
      if (cmd.mul) begin
         p_rr_ff <= PW'(zr_ff) * PW'(zr_ff);
         p_ii_ff <= PW'(zi_ff) * PW'(zi_ff);
         p_ri_ff <= PW'(zr_ff) * PW'(zi_ff);
      end
      if (cmd.step) begin
         zr_ff    <= efp_pkg::sat_word(nr_sum);
         zi_ff    <= efp_pkg::sat_word(ni_sum);
         count_ff <= count_ff + IW'(1);
      end
      if (cmd.emit)
         rsp_data_ff <= efp_pkg::RSP_DATA_W'({count_ff[CW-1:0], flip_row[DW-1:0], col_ff});
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

[src/escape_time_fractal_pixel.sv]
`timescale 1ns / 1ps
// Top level of the escape-time fractal pixel block (Mandelbrot / Julia).
// Depends on efp_pkg, efp_ctrl and efp_datapath.
//
// Takes one pixel request at a time and returns its escape count modulo 256,
// the column, and the row flipped to screen order. A request with final count
// n (before the modulo) passes from acceptance through two setup steps, then
// n+1 passes of the iteration (a multiplier stage forming the three 64-bit
// products of z, two squares and a cross term, then an update stage with the
// escape test and the saturating add of c), a step that loads the result
// register once it is free, and a return to idle for the next request. The result
// register lets the next request start while a result waits on rsp_tready.
// Configuration may only be written while no request is in flight.
module escape_time_fractal_pixel (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [efp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [efp_pkg::WORD_W-1:0]            csr_wdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [efp_pkg::REQ_DATA_W-1:0]        req_tdata,  // column, row
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [efp_pkg::RSP_DATA_W-1:0]        rsp_tdata   // pixel_column, screen_row, escape_count
);

   efp_pkg::efp_cmd_type    cmd;
   efp_pkg::efp_status_type status;

   efp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   efp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

[src/efp_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the escape-time fractal pixel block, bound to the top.
// Depends on efp_pkg.
module efp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [efp_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one request in flight at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a new result is only loaded as the block returns to idle
   a_emit_to_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result appeared while busy");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind escape_time_fractal_pixel efp_checker u_efp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/escape_time_fractal_pixel_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for escape_time_fractal_pixel: random pixel requests under several views.
// Each accepted request is scored against an in-bench fixed-point predictor. Depends on efp_pkg.
module escape_time_fractal_pixel_test;

   localparam int MAX_DIM    = efp_pkg::MAX_DIM;
   localparam int FRAC_BITS  = efp_pkg::FRAC_BITS;
   localparam int ITER_WIDTH = efp_pkg::ITER_WIDTH;
   localparam int DIM_W      = efp_pkg::DIM_W;
   localparam int HEIGHT_W   = efp_pkg::HEIGHT_W;
   localparam int WORD_W     = efp_pkg::WORD_W;
   localparam int STEP_W     = efp_pkg::STEP_W;
   localparam int COUNT_W    = efp_pkg::COUNT_W;
   localparam int CSR_IDX_W  = efp_pkg::CSR_IDX_W;
   localparam int REQ_DATA_W = efp_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = efp_pkg::RSP_DATA_W;

   localparam int WATCHDOG_LIMIT  = 500000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int REPORT_LIMIT    = 10;
   localparam int RANDOM_PHASES   = 13;
   localparam int PHASE_PIXELS    = 100;
   localparam longint WORD_MAX    = 64'sd2147483647;
   localparam longint WORD_MIN    = -64'sd2147483648;
   localparam logic [31:0] EXTREME_WORDS [3] = '{32'h80000000, 32'h7FFFFFFF, 32'h0};

   typedef struct {
      logic [DIM_W-1:0] column;
      logic [DIM_W-1:0] row;
   } pixel_request_type;

   typedef struct {
      logic [DIM_W-1:0]   column;
      logic [DIM_W-1:0]   screen_row;
      logic [COUNT_W-1:0] count;
   } pixel_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [WORD_W-1:0]      csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;   // column, row
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;        // pixel_column, screen_row, escape_count

   // predictor copy of the registers
   logic                   julia_sel = 1'b0;
   longint                 view_re = 0;
   longint                 view_im = 0;
   logic [STEP_W-1:0]      step_size = STEP_W'(268435);
   logic [ITER_WIDTH-1:0]  max_iter = ITER_WIDTH'(255);
   longint                 seed_re = 0;
   longint                 seed_im = 0;
   logic [HEIGHT_W-1:0]    rows_tall = HEIGHT_W'(MAX_DIM);

   // predictor copy of the iteration state
   longint                 zr = 0;
   longint                 zi = 0;
   longint                 cr = 0;
   longint                 ci = 0;
   logic [ITER_WIDTH-1:0]  iter_n = '0;

   pixel_request_type pixel_requests[$];
   pixel_result_type  expected_pixels[$];

   int req_gap_pct = 35;
   int rsp_stall_pct = 35;
   int hold_requests = 0;
   int holds_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int mismatch_count = 0;

   escape_time_fractal_pixel DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp_word(input longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   // |z|^2 < 4.0, both squares at full precision
   function automatic bit within_radius(input longint re, input longint im);
      logic [63:0] mag;
      mag = 64'(re * re) + 64'(im * im);
      return mag < (64'd1 << (2 * FRAC_BITS + 2));
   endfunction

   function automatic pixel_result_type escape_time_of(input logic [DIM_W-1:0] col,
                                                       input logic [DIM_W-1:0] row);
      longint           pre;
      longint           pim;
      longint           sq_diff;
      longint           cross_prod;
      longint           nr;
      longint           ni;
      pixel_result_type r;
      pre = clamp_word(view_re + longint'(col) * longint'(step_size));
      pim = clamp_word(view_im + longint'(row) * longint'(step_size));
      if (julia_sel) begin
         zr = pre;
         zi = pim;
         cr = seed_re;
         ci = seed_im;
      end else begin
         zr = 0;
         zi = 0;
         cr = pre;
         ci = pim;
      end
      iter_n = '0;
      while (iter_n < max_iter && within_radius(zr, zi)) begin
         sq_diff = zr * zr - zi * zi;
         cross_prod = zr * zi;
         nr = clamp_word((sq_diff >>> FRAC_BITS) + cr);
         ni = clamp_word((cross_prod >>> (FRAC_BITS - 1)) + ci);
         zr = nr;
         zi = ni;
         iter_n++;
      end
      r.column = col;
      // the flip wraps modulo the largest image size
      r.screen_row = DIM_W'(int'(rows_tall) - 1 - int'(row));
      r.count = iter_n[COUNT_W-1:0];
      return r;
   endfunction

   function automatic void note_mismatch(input string what, input longint want,
                                         input longint got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
   endfunction

   // request side: score on acceptance, then load the next request or idle
   always @(posedge clock) begin : req_side
      pixel_request_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_pixels.push_back(escape_time_of(req_tdata[DIM_W-1:0],
                                                     req_tdata[2*DIM_W-1:DIM_W]));
         if (!req_tvalid || req_tready) begin
            if (pixel_requests.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
               nxt = pixel_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= REQ_DATA_W'({nxt.row, nxt.column});
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result side: compare against the oldest prediction, then decide ready
   always @(posedge clock) begin : rsp_side
      pixel_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               note_mismatch("result with no request pending, column", -1,
                             rsp_tdata[DIM_W-1:0]);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata[DIM_W-1:0] !== want.column)
                  note_mismatch("pixel_column", want.column, rsp_tdata[DIM_W-1:0]);
               if (rsp_tdata[2*DIM_W-1:DIM_W] !== want.screen_row)
                  note_mismatch("screen_row", want.screen_row, rsp_tdata[2*DIM_W-1:DIM_W]);
               if (rsp_tdata[2*DIM_W+COUNT_W-1:2*DIM_W] !== want.count)
                  note_mismatch("escape_count", want.count,
                                rsp_tdata[2*DIM_W+COUNT_W-1:2*DIM_W]);
            end
         end
         if (hold_requests != holds_seen) begin
            holds_seen <= hold_requests;
            hold_left <= RSP_HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input efp_pkg::csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         efp_pkg::CSR_MODE:      julia_sel = value[0];
         efp_pkg::CSR_ORIGIN_RE: view_re = longint'(signed'(value));
         efp_pkg::CSR_ORIGIN_IM: view_im = longint'(signed'(value));
         efp_pkg::CSR_STEP:      step_size = value[STEP_W-1:0];
         efp_pkg::CSR_LIMIT:     max_iter = value[ITER_WIDTH-1:0];
         efp_pkg::CSR_CONST_RE:  seed_re = longint'(signed'(value));
         efp_pkg::CSR_CONST_IM:  seed_im = longint'(signed'(value));
         efp_pkg::CSR_HEIGHT:    rows_tall = value[HEIGHT_W-1:0];
         default:                ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic apply_view(input logic [31:0] mode, input logic [31:0] ore,
                             input logic [31:0] oim, input logic [31:0] stp,
                             input logic [31:0] lim, input logic [31:0] cre,
                             input logic [31:0] cim, input logic [31:0] hgt);
      write_reg(efp_pkg::CSR_MODE, mode);
      write_reg(efp_pkg::CSR_ORIGIN_RE, ore);
      write_reg(efp_pkg::CSR_ORIGIN_IM, oim);
      write_reg(efp_pkg::CSR_STEP, stp);
      write_reg(efp_pkg::CSR_LIMIT, lim);
      write_reg(efp_pkg::CSR_CONST_RE, cre);
      write_reg(efp_pkg::CSR_CONST_IM, cim);
      write_reg(efp_pkg::CSR_HEIGHT, hgt);
      @(negedge clock);
   endtask

   task automatic offer_pixel(input int col, input int row);
      pixel_request_type p;
      p.column = DIM_W'(col);
      p.row = DIM_W'(row);
      pixel_requests.push_back(p);
   endtask

   // hold the sender until every result is back and the block has gone idle
   task automatic drain_results();
      @(negedge clock);
      while (pixel_requests.size() != 0 || req_tvalid || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_view(input int phase);
      logic [31:0] mode;
      logic [31:0] ore;
      logic [31:0] oim;
      logic [31:0] stp;
      logic [31:0] lim;
      logic [31:0] cre;
      logic [31:0] cim;
      logic [31:0] hgt;
      mode = $urandom_range(1);
      case ($urandom_range(3))
         0: begin
            // whole set in view
            ore = 32'hD8000000 + $urandom_range(32'h10000000);
            oim = 32'hE0000000 + $urandom_range(32'h08000000);
            stp = $urandom_range(32'h10000, 32'h48000);
         end
         1: begin
            // close zoom near the boundary
            ore = 32'hF4000000 + $urandom_range(32'h00800000) - 32'h00400000;
            oim = 32'h01999999 + $urandom_range(32'h00800000) - 32'h00400000;
            stp = $urandom_range(1, 4096);
         end
         2: begin
            ore = $urandom;
            oim = $urandom;
            stp = $urandom;
         end
         default: begin
            ore = EXTREME_WORDS[$urandom_range(2)];
            oim = EXTREME_WORDS[$urandom_range(2)];
            stp = $urandom_range(1) ? 32'h7FFFFFFF : 32'h0;
         end
      endcase
      if ($urandom_range(1)) begin
         cre = $urandom;
         cim = $urandom;
      end else begin
         cre = $urandom_range(32'h20000000) - 32'h10000000;
         cim = $urandom_range(32'h20000000) - 32'h10000000;
      end
      case ($urandom_range(4))
         0:       lim = $urandom_range(3);
         1:       lim = $urandom_range(4, 64);
         2:       lim = 255 + $urandom_range(1);
         3:       lim = $urandom_range(257, 400);
         default: lim = $urandom_range(1, 200);
      endcase
      case ($urandom_range(7))
         0:       hgt = 0;
         1:       hgt = 1;
         2:       hgt = $urandom_range(4097, 8191);
         3:       hgt = MAX_DIM;
         default: hgt = $urandom_range(1, MAX_DIM);
      endcase
      if (phase == 1) begin
         lim = 20;
      end else if (phase == 2) begin
         // largest limit, but every point lies far right and leaves at once
         lim = 32'hFFFF;
         ore = 32'h30000000 + $urandom_range(32'h01000000);
         stp = $urandom_range(32'h100000);
      end else if (phase == 3) begin
         lim = 0;
      end
      apply_view(mode, ore, oim, stp, lim, cre, cim, hgt);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // registers at their reset values
      @(negedge clock);
      offer_pixel(0, 0);
      offer_pixel(4095, 4095);
      offer_pixel(4095, 0);
      offer_pixel(0, 4095);
      offer_pixel(12'hAAA, 12'h555);
      offer_pixel(12'h555, 12'hAAA);
      drain_results();

      // period-two point under the largest limit, saturated point, one-row image
      apply_view(0, 32'hE0000000, 32'hE8000000, 32'h00100000, 32'hFFFF, 0, 0, 1);
      offer_pixel(256, 384);
      offer_pixel(0, 0);
      offer_pixel(4095, 4095);
      drain_results();

      // zero limit, extreme origins and step, zero height
      apply_view(1, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0,
                 32'h7FFFFFFF, 32'h80000000, 0);
      offer_pixel(0, 0);
      offer_pixel(4095, 4095);
      offer_pixel(1, 4095);
      drain_results();

      // Julia seed already outside, and ordinary Julia orbits
      apply_view(1, 32'hF0000000, 32'hF0000000, 32'h00200000, 100,
                 32'hF3333334, 32'h027EF9DB, MAX_DIM);
      offer_pixel(511, 0);
      offer_pixel(128, 128);
      offer_pixel(0, 0);
      drain_results();

      // constant at the word limits drives the iterate into saturation
      apply_view(1, 0, 0, 32'h10000000, 10, 32'h7FFFFFFF, 32'h80000000, 2048);
      offer_pixel(1, 0);
      offer_pixel(1, 1);
      offer_pixel(0, 1);
      drain_results();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         random_view(p);
         req_gap_pct = (p == 0) ? 0 : 35;
         rsp_stall_pct = (p == 0) ? 0 : 35;
         repeat (PHASE_PIXELS) offer_pixel($urandom_range(4095), $urandom_range(4095));
         // stall the result side long enough to back up the request side
         if (p == 1)
            hold_requests = hold_requests + 1;
         drain_results();
      end

      if (mismatch_count == 0 && expected_pixels.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
